[rtl/dap_pkg.sv]
// dap_pkg: types, codes and character constants for the dotted address parser
// no dependencies; imported by dap_step and dotted_address_parser
`default_nettype none

package dap_pkg;

	localparam int ORDINAL_WIDTH = 64;
	localparam int ORDINAL_BITS_DEF = 64;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_DOT = 8'h2e;
	localparam logic [7:0] CHAR_A = 8'h61;
	localparam logic [7:0] CHAR_Z = 8'h7a;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_NUM = 2'd1,
		MODE_ALPHA = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_EMPTY = 3'd1,
		ST_LEADZERO = 3'd2,
		ST_BADCHAR = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic {
		KIND_NUM = 1'b0,
		KIND_ALPHA = 1'b1
	} kind_t;

	// parser control state between the state registers and the step logic
	typedef struct packed {
		mode_t mode;
		status_t err;
	} ctl_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic final_char;
	} chr_t;

	typedef struct packed {
		logic component_kind;
		logic [ORDINAL_WIDTH-1:0] ordinal;
		logic [2:0] status;
		logic end_of_address;
	} res_t;

endpackage

`default_nettype wire

[rtl/dap_step.sv]
// dap_step: next-state and result logic for one character of a dotted address
// depends on dap_pkg
`default_nettype none

module dap_step #(
	parameter int ORDINAL_BITS = dap_pkg::ORDINAL_BITS_DEF
) (
	input wire dap_pkg::chr_t chr,
	input wire dap_pkg::ctl_t ctl,
	input wire logic [ORDINAL_BITS-1:0] acc,
	output dap_pkg::ctl_t ctl_next,
	output logic [ORDINAL_BITS-1:0] acc_next,
	output logic res_fire,
	output dap_pkg::res_t res
);
	import dap_pkg::*;

	localparam int SW = ORDINAL_BITS + 6;

	logic is_digit;
	logic is_lower;
	logic base26;
	logic [7:0] letter_val;
	logic [7:0] digit_val;
	logic [4:0] addend;
	logic [ORDINAL_BITS-1:0] acc_op;
	logic [SW-1:0] a_ext;
	logic [SW-1:0] prod;
	logic [SW-1:0] sum;
	logic mac_ovf;
	logic [ORDINAL_BITS-1:0] mac_val;

	assign is_digit = chr.char_code inside {[CHAR_ZERO:CHAR_NINE]};
	assign is_lower = chr.char_code inside {[CHAR_A:CHAR_Z]};

	// shared multiply-add: acc * base + digit, base 10 or 26
	assign base26 = (ctl.mode == MODE_ALPHA) || (ctl.mode == MODE_IDLE && is_lower);
	assign letter_val = chr.char_code - CHAR_A + 8'd1;
	assign digit_val = chr.char_code - CHAR_ZERO;
	assign addend = base26 ? letter_val[4:0] : digit_val[4:0];
	assign acc_op = (ctl.mode == MODE_IDLE) ? '0 : acc;
	assign a_ext = SW'(acc_op);
	assign prod = base26 ? (a_ext << 4) + (a_ext << 3) + (a_ext << 1)
		: (a_ext << 3) + (a_ext << 1);
	assign sum = prod + SW'(addend);
	assign mac_ovf = |sum[SW-1:ORDINAL_BITS];
	assign mac_val = sum[ORDINAL_BITS-1:0];

	always_comb begin
		mode_t m;
		status_t e;
		logic [ORDINAL_BITS-1:0] a;
		logic dot_done;
		m = ctl.mode;
		e = ctl.err;
		a = acc;
		dot_done = 1'b0;
		res_fire = 1'b0;
		res = '0;
		if (ctl.err == ST_OK) begin
			if (chr.char_code == CHAR_DOT) begin
				if (ctl.mode == MODE_IDLE) begin
					e = ST_EMPTY;
				end else begin
					res_fire = 1'b1;
					res.component_kind = (ctl.mode == MODE_ALPHA) ? KIND_ALPHA : KIND_NUM;
					res.ordinal = ORDINAL_WIDTH'(acc);
					res.status = ST_OK;
					res.end_of_address = chr.final_char;
					m = MODE_IDLE;
					a = '0;
					dot_done = 1'b1;
				end
			end else if (ctl.mode == MODE_IDLE) begin
				if (chr.char_code == CHAR_ZERO) begin
					e = ST_LEADZERO;
				end else if (is_digit || is_lower) begin
					m = is_digit ? MODE_NUM : MODE_ALPHA;
					if (mac_ovf) begin
						a = '0;
						e = ST_OVERFLOW;
					end else begin
						a = mac_val;
					end
				end else begin
					e = ST_BADCHAR;
				end
			end else if ((ctl.mode == MODE_NUM && is_digit)
				|| (ctl.mode == MODE_ALPHA && is_lower)) begin
				if (mac_ovf) begin
					e = ST_OVERFLOW;
				end else begin
					a = mac_val;
				end
			end else begin
				e = ST_BADCHAR;
			end
		end
		// end of address: closing result, then back to the reset state
		if (chr.final_char && !dot_done) begin
			res_fire = 1'b1;
			res.end_of_address = 1'b1;
			if (e != ST_OK) begin
				res.component_kind = KIND_NUM;
				res.ordinal = '0;
				res.status = e;
			end else begin
				res.component_kind = (m == MODE_ALPHA) ? KIND_ALPHA : KIND_NUM;
				res.ordinal = ORDINAL_WIDTH'(a);
				res.status = ST_OK;
			end
		end
		if (chr.final_char) begin
			m = MODE_IDLE;
			e = ST_OK;
			a = '0;
		end
		ctl_next.mode = m;
		ctl_next.err = e;
		acc_next = a;
	end

endmodule

`default_nettype wire

[rtl/dotted_address_parser.sv]
// dotted_address_parser: top level, input register, parser state and result register
// depends on dap_pkg and dap_step
`default_nettype none

// usage
// - chr channel (chr_valid, chr_stall, chr): one character transaction per cycle
//   while chr_stall is low; chr.final_char marks the last character of an address
// - res channel: result transactions (res_valid, res_stall, res), at most one per
//   character; a component goes out at its dot, the last one at the final character
// - any error is sticky until the final character, which then carries a single
//   error result with status set and end_of_address high; components already
//   sent for that address are to be dropped by the receiver
// - path: a character goes through the input register, then the parse step
//   into the result register
// - throughput: one character per cycle unless stalled; each accumulate step
//   is one constant multiply-add by 10 or 26, overflow-checked on ORDINAL_BITS bits
// - reset: clears both stages and the parser state; the first character
//   afterwards starts a new address
// - when res_stall is high while a result is held, the parse stage halts and
//   chr_stall rises once the input register is also full; a held result does
//   not change
module dotted_address_parser #(
	parameter int ORDINAL_BITS = dap_pkg::ORDINAL_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic chr_valid,
	output logic chr_stall,
	input wire dap_pkg::chr_t chr,
	output logic res_valid,
	input wire logic res_stall,
	output dap_pkg::res_t res
);
	import dap_pkg::*;

	// input register stage
	logic valid_s1;
	chr_t chr_s1;

	// parser state
	ctl_t ctl_q;
	logic [ORDINAL_BITS-1:0] acc_q;

	// result register
	logic res_valid_q;
	res_t res_q;

	// step logic outputs
	ctl_t ctl_next;
	logic [ORDINAL_BITS-1:0] acc_next;
	logic step_fire;
	res_t step_res;

	logic res_free;
	logic advance;

	// the result register can take a new value when empty or being drained
	assign res_free = !res_valid_q || !res_stall;
	assign advance = valid_s1 && res_free;
	assign chr_stall = valid_s1 && !res_free;

	dap_step #(
		.ORDINAL_BITS(ORDINAL_BITS)
	) u_step (
		.chr(chr_s1),
		.ctl(ctl_q),
		.acc(acc_q),
		.ctl_next(ctl_next),
		.acc_next(acc_next),
		.res_fire(step_fire),
		.res(step_res)
	);

	// input register: refilled whenever it is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!chr_stall) begin
			valid_s1 <= chr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!chr_stall && chr_valid) begin
			chr_s1 <= chr;
		end
	end

	// parser state moves once per character that leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.mode <= MODE_IDLE;
			ctl_q.err <= ST_OK;
			acc_q <= '0;
		end else if (advance) begin
			ctl_q <= ctl_next;
			acc_q <= acc_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= advance && step_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_fire) begin
			res_q <= step_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

`default_nettype wire
